### rtl/core/fp8_block_scaled_dot_product_macros.svh
// Assertion macros for the block-scaled dot product RTL.
`ifndef FP8_BLOCK_SCALED_DOT_PRODUCT_MACROS_SVH
`define FP8_BLOCK_SCALED_DOT_PRODUCT_MACROS_SVH

// Same-cycle implication, checked on clk and idle while rst_n is low.
`define FBSD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and idle while rst_n is low.
`define FBSD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/fbsd_pkg.sv
// Types, constants and helper functions of the block-scaled dot product.
package fbsd_pkg;

  localparam logic [1:0] CLS_ZERO = 2'd0;
  localparam logic [1:0] CLS_NORM = 2'd1;
  localparam logic [1:0] CLS_INF  = 2'd2;
  localparam logic [1:0] CLS_NAN  = 2'd3;

  localparam int          QDEPTH = 4;
  localparam int          QPW    = 2;
  localparam logic [16:0] ROW_LEN_RESET = 17'd128;

  // Unpacked double: normal values carry the hidden one at sig[52];
  // a NaN carries its mantissa field in sig[51:0].
  typedef struct packed {
    logic [1:0]  cls;
    logic        sgn;
    logic [10:0] exp;
    logic [52:0] sig;
  } dbl_t;

  typedef struct packed {
    dbl_t       prod;
    logic [7:0] scale;
    logic       blk_end;
    logic       row_end;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam dbl_t DZERO = '{cls: CLS_ZERO, sgn: 1'b0, exp: 11'd0, sig: 53'd0};
  localparam dbl_t DEFAULT_NAN = '{cls: CLS_NAN, sgn: 1'b1, exp: 11'd0,
                                   sig: 53'h8000000000000};

  function automatic logic [3:0] lz8(input logic [7:0] v);
    logic [3:0] r;
    logic       found;
    r = 4'd8;
    found = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!found && v[i]) begin
        r = 4'(7 - i);
        found = 1'b1;
      end
    end
    return r;
  endfunction

  // Leading zeros of a 56-bit word, as byte groups then within the byte.
  function automatic logic [5:0] lzc56(input logic [55:0] v);
    logic [5:0] r;
    logic       found;
    logic [7:0] g;
    r = 6'd56;
    found = 1'b0;
    for (int i = 6; i >= 0; i--) begin
      g = v[i*8 +: 8];
      if (!found && (g != 8'd0)) begin
        r = 6'((6 - i) * 8) + 6'(lz8(g));
        found = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

### rtl/core/fbsd_front.sv
// Front end: row position tracking, weight and activation decode, exact product.
module fbsd_front
  import fbsd_pkg::*;
#(
  parameter int BLOCK_SIZE     = 128,
  parameter int MAX_ROW_LENGTH = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_weight_code,
  input  logic [31:0] in_activation_bits,
  input  logic [7:0]  in_block_scale,
  input  q_stat_t     q_stat,
  output logic        push,
  output q_entry_t    push_entry
);

  localparam int PW = $clog2(MAX_ROW_LENGTH + 1);
  localparam int BW = $clog2(BLOCK_SIZE + 1);
  localparam int CW = (PW > 17) ? PW : 17;

  logic [16:0]   row_length_r, row_length_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [BW-1:0] blk_r, blk_nxt;

  logic [CW-1:0] rl, len, next;
  logic [BW-1:0] blk_inc;
  logic          row_end, blk_end;

  logic        w_sgn, w_nan, w_zero;
  logic [3:0]  w_sig;
  logic signed [11:0] w_exp;
  logic [7:0]  a_e;
  logic [22:0] a_f;
  logic        a_sgn, a_nan, a_inf, a_zero;
  logic [23:0] a_sig;
  logic [5:0]  a_lz;
  logic signed [11:0] a_exp;
  logic [27:0] prod;
  logic signed [11:0] p_exp;
  dbl_t        p;

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  always_comb begin
    rl = CW'(row_length_r);
    if (rl == '0) begin
      len = CW'(1);
    end else if (rl > CW'(MAX_ROW_LENGTH)) begin
      len = CW'(MAX_ROW_LENGTH);
    end else begin
      len = rl;
    end
    next    = CW'(pos_r) + CW'(1);
    blk_inc = blk_r + BW'(1);
    row_end = (next >= len);
    blk_end = row_end || (blk_inc == BW'(BLOCK_SIZE));
  end

  // Weight decode into a 4-bit normalised significand.
  always_comb begin
    w_sgn  = in_weight_code[7];
    w_nan  = (in_weight_code[6:0] == 7'h7f);
    w_zero = (in_weight_code[6:0] == 7'h00);
    if (in_weight_code[6:3] != 4'd0) begin
      w_sig = {1'b1, in_weight_code[2:0]};
      w_exp = $signed({8'd0, in_weight_code[6:3]}) - 12'sd7;
    end else if (in_weight_code[2]) begin
      w_sig = {in_weight_code[2:0], 1'b0};
      w_exp = -12'sd7;
    end else if (in_weight_code[1]) begin
      w_sig = {in_weight_code[1:0], 2'b00};
      w_exp = -12'sd8;
    end else begin
      w_sig = 4'b1000;
      w_exp = -12'sd9;
    end
  end

  // Activation decode; subnormals are normalised here.
  always_comb begin
    a_sgn  = in_activation_bits[31];
    a_e    = in_activation_bits[30:23];
    a_f    = in_activation_bits[22:0];
    a_nan  = (a_e == 8'hff) && (a_f != 23'd0);
    a_inf  = (a_e == 8'hff) && (a_f == 23'd0);
    a_zero = (a_e == 8'h00) && (a_f == 23'd0);
    a_lz   = lzc56({a_f, 33'd0});
    if (a_e != 8'h00) begin
      a_sig = {1'b1, a_f};
      a_exp = $signed({4'd0, a_e}) - 12'sd127;
    end else begin
      a_sig = 24'({a_f, 1'b0} << a_lz);
      a_exp = -12'sd127 - $signed({6'd0, a_lz});
    end
  end

  always_comb begin
    prod  = 28'(w_sig) * 28'(a_sig);
    p_exp = w_exp + a_exp + 12'sd1023 + $signed({11'd0, prod[27]});
    p.cls = CLS_NORM;
    p.sgn = w_sgn ^ a_sgn;
    p.exp = p_exp[10:0];
    p.sig = prod[27] ? {prod, 25'd0} : {prod[26:0], 26'd0};
    if (w_nan) begin
      p = '{cls: CLS_NAN, sgn: w_sgn, exp: 11'd0, sig: 53'h8000000000000};
    end else if (a_nan) begin
      p = '{cls: CLS_NAN, sgn: a_sgn, exp: 11'd0, sig: {2'b01, a_f[21:0], 29'd0}};
    end else if (a_inf) begin
      if (w_zero) begin
        p = DEFAULT_NAN;
      end else begin
        p = '{cls: CLS_INF, sgn: w_sgn ^ a_sgn, exp: 11'd0, sig: 53'd0};
      end
    end else if (w_zero || a_zero) begin
      p = '{cls: CLS_ZERO, sgn: w_sgn ^ a_sgn, exp: 11'd0, sig: 53'd0};
    end
    push_entry.prod    = p;
    push_entry.scale   = in_block_scale;
    push_entry.blk_end = blk_end;
    push_entry.row_end = row_end;
  end

  always_comb begin
    row_length_nxt = cfg_wr_en ? cfg_wr_data : row_length_r;
    pos_nxt = pos_r;
    blk_nxt = blk_r;
    if (push) begin
      if (row_end) begin
        pos_nxt = '0;
        blk_nxt = '0;
      end else begin
        pos_nxt = next[PW-1:0];
        blk_nxt = (blk_inc == BW'(BLOCK_SIZE)) ? '0 : blk_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r <= ROW_LEN_RESET;
      pos_r        <= '0;
      blk_r        <= '0;
    end else begin
      row_length_r <= row_length_nxt;
      pos_r        <= pos_nxt;
      blk_r        <= blk_nxt;
    end
  end

endmodule

### rtl/core/fbsd_queue.sv
// Short queue of decoded elements between the front and back ends.
`include "fp8_block_scaled_dot_product_macros.svh"
module fbsd_queue
  import fbsd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  input  logic     pop,
  output q_entry_t head,
  output q_stat_t  stat
);

  q_entry_t        slot_r [QDEPTH];
  logic [QPW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QPW:0]    count_r, count_nxt;

  assign head       = slot_r[rd_ptr_r];
  assign stat.full  = (count_r == (QPW+1)'(QDEPTH));
  assign stat.empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPW'(1) : rd_ptr_r;
    count_nxt  = count_r + (QPW+1)'(push) - (QPW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `FBSD_ASSERT_IMP(a_no_overflow, push, !stat.full, "push into a full queue")
  `FBSD_ASSERT_IMP(a_no_underflow, pop, !stat.empty, "pop from an empty queue")
  `FBSD_ASSERT_NXT(a_count_up, push && !pop, count_r == $past(count_r) + (QPW+1)'(1), "count lost a beat")
  `FBSD_ASSERT_NXT(a_ptr_gap, 1'b1, wr_ptr_r == QPW'(rd_ptr_r + count_r[QPW-1:0]), "pointers and count disagree")

endmodule

### rtl/core/fbsd_dadd.sv
// Four-step double-precision adder, round to nearest even.
module fbsd_dadd
  import fbsd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  dbl_t op_a,
  input  dbl_t op_b,
  output dbl_t res,
  output logic done
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ADD  = 2'd1;
  localparam logic [1:0] ST_NORM = 2'd2;
  localparam logic [1:0] ST_RND  = 2'd3;

  logic [1:0]  step_r, step_nxt;
  logic        done_r, done_nxt;
  logic        spec_r;
  dbl_t        spec_res_r, res_r;
  logic        sgn_r, sub_r, zero_r;
  logic [11:0] exp_r;
  logic [55:0] big_r, small_r, n_r;
  logic [56:0] sum_r;

  logic        a_big, spec;
  dbl_t        big, sml, spec_res;
  logic [10:0] d;
  logic [5:0]  dc;
  logic [119:0] t;
  logic [55:0] small_x;
  logic [56:0] sum;
  logic [5:0]  lz;
  logic [55:0] n;
  logic [11:0] n_exp;
  logic        inc;
  logic [53:0] rs;

  assign res  = res_r;
  assign done = done_r;

  // Operand compare, special values and alignment of the smaller operand.
  always_comb begin
    a_big = (op_a.exp > op_b.exp) || ((op_a.exp == op_b.exp) && (op_a.sig >= op_b.sig));
    big   = a_big ? op_a : op_b;
    sml   = a_big ? op_b : op_a;
    d     = big.exp - sml.exp;
    dc    = (d > 11'd63) ? 6'd63 : d[5:0];
    t     = {sml.sig, 3'b000, 64'd0} >> dc;
    small_x = {t[119:65], t[64] | (|t[63:0])};
    spec     = 1'b1;
    spec_res = DZERO;
    if (op_a.cls == CLS_NAN) begin
      spec_res = op_a;
    end else if (op_b.cls == CLS_NAN) begin
      spec_res = op_b;
    end else if ((op_a.cls == CLS_INF) && (op_b.cls == CLS_INF) && (op_a.sgn != op_b.sgn)) begin
      spec_res = DEFAULT_NAN;
    end else if (op_a.cls == CLS_INF) begin
      spec_res = op_a;
    end else if (op_b.cls == CLS_INF) begin
      spec_res = op_b;
    end else if ((op_a.cls == CLS_ZERO) && (op_b.cls == CLS_ZERO)) begin
      spec_res = DZERO;
      spec_res.sgn = op_a.sgn & op_b.sgn;
    end else if (op_a.cls == CLS_ZERO) begin
      spec_res = op_b;
    end else if (op_b.cls == CLS_ZERO) begin
      spec_res = op_a;
    end else begin
      spec = 1'b0;
    end
  end

  always_comb begin
    sum = sub_r ? ({1'b0, big_r} - {1'b0, small_r}) : ({1'b0, big_r} + {1'b0, small_r});
  end

  // Normalise: one right step on carry out, else a left shift after cancellation.
  always_comb begin
    lz = lzc56(sum_r[55:0]);
    if (sum_r[56]) begin
      n     = {sum_r[56:2], sum_r[1] | sum_r[0]};
      n_exp = exp_r + 12'd1;
    end else begin
      n     = sum_r[55:0] << lz;
      n_exp = exp_r - 12'(lz);
    end
  end

  always_comb begin
    inc = n_r[2] & (n_r[1] | n_r[0] | n_r[3]);
    rs  = {1'b0, n_r[55:3]} + 54'(inc);
  end

  always_comb begin
    step_nxt = ST_IDLE;
    done_nxt = 1'b0;
    case (step_r)
      ST_IDLE: step_nxt = start ? ST_ADD : ST_IDLE;
      ST_ADD:  step_nxt = ST_NORM;
      ST_NORM: step_nxt = ST_RND;
      ST_RND:  done_nxt = 1'b1;
      default: step_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (step_r)
      ST_IDLE: begin
        spec_r     <= spec;
        spec_res_r <= spec_res;
        sgn_r      <= big.sgn;
        sub_r      <= big.sgn ^ sml.sgn;
        exp_r      <= {1'b0, big.exp};
        big_r      <= {big.sig, 3'b000};
        small_r    <= small_x;
      end
      ST_ADD: begin
        sum_r <= sum;
      end
      ST_NORM: begin
        zero_r <= (sum_r == 57'd0);
        n_r    <= n;
        exp_r  <= n_exp;
      end
      ST_RND: begin
        if (spec_r) begin
          res_r <= spec_res_r;
        end else if (zero_r) begin
          res_r <= DZERO;
        end else if (rs[53]) begin
          res_r <= '{cls: CLS_NORM, sgn: sgn_r, exp: 11'(exp_r + 12'd1), sig: rs[53:1]};
        end else begin
          res_r <= '{cls: CLS_NORM, sgn: sgn_r, exp: exp_r[10:0], sig: rs[52:0]};
        end
      end
      default: res_r <= res_r;
    endcase
  end

endmodule

### rtl/core/fbsd_back.sv
// Back end: block and row accumulation, fp32 rounding and the result register.
module fbsd_back
  import fbsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  q_entry_t    head,
  input  q_stat_t     q_stat,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_row_result_bits
);

  localparam logic [1:0] BK_IDLE = 2'd0;
  localparam logic [1:0] BK_ELEM = 2'd1;
  localparam logic [1:0] BK_BLK  = 2'd2;
  localparam logic [1:0] BK_CONV = 2'd3;

  logic [1:0]  state_r, state_nxt;
  dbl_t        block_r, block_nxt;
  dbl_t        row_r, row_nxt;
  q_entry_t    cur_r, cur_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_bits_r, out_bits_nxt;

  logic        start, add_done;
  dbl_t        op_a, op_b, add_res, scaled;
  logic [31:0] conv;

  function automatic dbl_t scale_dbl(input dbl_t v, input logic [7:0] s);
    dbl_t r;
    r = v;
    if (v.cls == CLS_NORM) begin
      r.exp = 11'({1'b0, v.exp} + {4'd0, s} - 12'd127);
    end
    return r;
  endfunction

  // Double to fp32, round to nearest even, subnormals and overflow included.
  function automatic logic [31:0] to_fp32(input dbl_t v);
    logic signed [12:0] fe;
    logic [5:0]   sh;
    logic [119:0] t;
    logic [23:0]  q;
    logic         inc;
    logic [7:0]   ef;
    logic [30:0]  body;
    logic [31:0]  r;
    fe = $signed({2'b00, v.exp}) - 13'sd896;
    if (fe >= 13'sd1) begin
      sh = 6'd29;
    end else if (fe < -13'sd33) begin
      sh = 6'd63;
    end else begin
      sh = 6'(13'sd30 - fe);
    end
    t    = {v.sig, 67'd0} >> sh;
    q    = t[90:67];
    inc  = t[66] & ((|t[65:0]) | q[0]);
    ef   = (fe >= 13'sd1) ? fe[7:0] : 8'd0;
    body = {ef, q[22:0]} + 31'(inc);
    case (v.cls)
      CLS_ZERO: r = {v.sgn, 31'd0};
      CLS_INF:  r = {v.sgn, 8'hff, 23'd0};
      CLS_NAN:  r = {v.sgn, 8'hff, v.sig[51:29]};
      default:  r = (fe >= 13'sd255) ? {v.sgn, 8'hff, 23'd0} : {v.sgn, body};
    endcase
    return r;
  endfunction

  fbsd_dadd u_dadd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op_a  (op_a),
    .op_b  (op_b),
    .res   (add_res),
    .done  (add_done)
  );

  assign out_valid           = out_valid_r;
  assign out_row_result_bits = out_bits_r;
  assign scaled              = scale_dbl(add_res, cur_r.scale);
  assign conv                = to_fp32(row_r);

  always_comb begin
    state_nxt     = state_r;
    block_nxt     = block_r;
    row_nxt       = row_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_bits_nxt  = out_bits_r;
    start         = 1'b0;
    pop           = 1'b0;
    op_a          = block_r;
    op_b          = head.prod;
    case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          start     = 1'b1;
          pop       = 1'b1;
          cur_nxt   = head;
          state_nxt = BK_ELEM;
        end
      end
      BK_ELEM: begin
        if (add_done) begin
          if (cur_r.blk_end) begin
            // scale the finished block and fold it into the row total
            start     = 1'b1;
            op_a      = row_r;
            op_b      = scaled;
            block_nxt = DZERO;
            state_nxt = BK_BLK;
          end else begin
            block_nxt = add_res;
            if (!q_stat.empty) begin
              start   = 1'b1;
              pop     = 1'b1;
              op_a    = add_res;
              cur_nxt = head;
            end else begin
              state_nxt = BK_IDLE;
            end
          end
        end
      end
      BK_BLK: begin
        if (add_done) begin
          row_nxt = add_res;
          if (cur_r.row_end) begin
            state_nxt = BK_CONV;
          end else if (!q_stat.empty) begin
            start     = 1'b1;
            pop       = 1'b1;
            op_a      = DZERO;
            cur_nxt   = head;
            state_nxt = BK_ELEM;
          end else begin
            state_nxt = BK_IDLE;
          end
        end
      end
      BK_CONV: begin
        // hold until the result register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_bits_nxt  = conv;
          row_nxt       = DZERO;
          state_nxt     = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      block_r     <= DZERO;
      row_r       <= DZERO;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      block_r     <= block_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_bits_r <= out_bits_nxt;
  end

endmodule

### rtl/core/fp8_block_scaled_dot_product.sv
// Top level of the fp8 e4m3 block-scaled row dot product.
// Usage: each input beat carries one row element (e4m3 weight byte, fp32
// activation bits, ue8m0 block scale). After row_length beats one output beat
// carries the fp32 dot product of the row; beats move when valid is high and
// stall is low. cfg_wr_en with cfg_wr_data sets row_length; the user is to
// write it only while idle, and the block itself does not enforce that.
// The back end's double adder finishes each element before it takes another;
// a block end adds the scaled add into the row total, and a row end adds the
// fp32 rounding into the result register and a pass back through idle.
// The front end takes one beat per cycle until its 4-entry queue is full,
// then raises in_stall. A row's last beat passes the queue, the element add,
// the scaled add into the row total and fp32 rounding before out_valid rises.
// Reset: rst_n low clears the position counters, the sums and the queue, and
// sets row_length to 128.
// A stalled output holds its result; the back end then waits in rounding
// while the queue keeps taking elements until it is full.
module fp8_block_scaled_dot_product
  import fbsd_pkg::*;
#(
  parameter int BLOCK_SIZE     = 128,
  parameter int MAX_ROW_LENGTH = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_weight_code,
  input  logic [31:0] in_activation_bits,
  input  logic [7:0]  in_block_scale,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_row_result_bits
);

  q_stat_t  q_stat;
  q_entry_t push_entry, head;
  logic     push, pop;

  fbsd_front #(
    .BLOCK_SIZE     (BLOCK_SIZE),
    .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_weight_code     (in_weight_code),
    .in_activation_bits (in_activation_bits),
    .in_block_scale     (in_block_scale),
    .q_stat             (q_stat),
    .push               (push),
    .push_entry         (push_entry)
  );

  fbsd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (q_stat)
  );

  fbsd_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head                (head),
    .q_stat              (q_stat),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_row_result_bits (out_row_result_bits)
  );

endmodule
